[rtl/nf4q_pkg.sv]
// package: shared types, constants and helper functions of the nf4 quantizer
package nf4q_pkg;

  localparam int unsigned AddrW = 20;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_SCALE = 2'd1,
    KIND_SUPER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_WEIGHT_BASE = 2'd0,
    REG_SCALE_BASE  = 2'd1,
    REG_SUPER_BASE  = 2'd2
  } reg_idx_e;

  // one result item
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload;
    logic [AddrW-1:0]  address;
    logic              run_end;
  } result_t;

  // back-end job descriptor: one closed block
  typedef struct packed {
    logic [8:0] fill;       // samples in block (1..BLOCK_SIZE)
    logic [6:0] peak;       // block scale
    logic       emit_super; // superblock scale follows
    logic [6:0] super_peak; // superblock scale value
    logic       fin;        // end of range: counters return to zero
  } job_t;

  // nf4 levels floored to Q2.6
  function automatic logic signed [7:0] nf4_level(input logic [3:0] idx);
    logic signed [7:0] r;
    begin
      case (idx)
        4'd0:    r = -8'sd64;
        4'd1:    r = -8'sd45;
        4'd2:    r = -8'sd34;
        4'd3:    r = -8'sd26;
        4'd4:    r = -8'sd19;
        4'd5:    r = -8'sd12;
        4'd6:    r = -8'sd6;
        4'd7:    r = 8'sd0;
        4'd8:    r = 8'sd5;
        4'd9:    r = 8'sd10;
        4'd10:   r = 8'sd15;
        4'd11:   r = 8'sd21;
        4'd12:   r = 8'sd28;
        4'd13:   r = 8'sd36;
        4'd14:   r = 8'sd46;
        default: r = 8'sd64;
      endcase
      return r;
    end
  endfunction

  // nearest code to normalized value n (-64..64), ties to the lower code;
  // levels ascend, so the nearest is found by counting midpoints below n
  function automatic logic [3:0] nf4_map(input logic signed [7:0] n);
    logic [3:0] c;
    logic signed [8:0] s;
    begin
      c = 4'd0;
      for (int i = 0; i < 15; i++) begin
        s = 9'(nf4_level(4'(i))) + 9'(nf4_level(4'(i + 1)));
        // n strictly beyond midpoint: 2n > lo+hi
        if ($signed({n, 1'b0}) > s) c = c + 4'd1;
      end
      return c;
    end
  endfunction

endpackage

[rtl/nf4q_if.sv]
// interface: valid/ready channel carrying a payload of type T
interface nf4q_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/nf4q_in_t.sv]
// package: input item type
package nf4q_in_pkg;
  typedef struct packed {
    logic signed [7:0] sample;
    logic              final_req;
  } in_item_t;
endpackage

[rtl/nf4q_div.sv]
// module: radix-2 restoring divider, 13-bit dividend by 7-bit divisor
module nf4q_div
  import nf4q_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [12:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [12:0] quot_o
);
  logic [12:0] quot_q, quot_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  dvs_q;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [8:0]  trial;

  // one quotient bit per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[12]} - {2'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 4'd13;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[8]) begin
        rem_d  = trial[7:0];
        quot_d = {quot_q[11:0], 1'b1};
      end else begin
        rem_d  = {rem_q[6:0], quot_q[12]};
        quot_d = {quot_q[11:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

[rtl/nf4q_front.sv]
// module: front end, stores samples, tracks peaks, closes blocks into jobs
module nf4q_front
  import nf4q_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE   = 64,
  parameter int unsigned SUPER_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_sample_i,
  input  logic        in_final_i,
  // job handoff
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_ready_i,
  // back end releases the buffer when done reading
  input  logic        buf_free_i,
  // buffer read port
  input  logic [$clog2(BLOCK_SIZE)-1:0] rd_addr_i,
  output logic [7:0]  rd_data_o
);
  localparam int unsigned IdxW = $clog2(BLOCK_SIZE);
  localparam int unsigned SbW  = $clog2(SUPER_BLOCKS + 1);

  logic [7:0] mem_q [BLOCK_SIZE];
  logic [8:0] fill_q;
  logic [6:0] peak_q, speak_q;
  logic [SbW-1:0] bdone_q;
  logic       full_q;   // block handed to back end, buffer in use
  logic       jv_q;
  job_t       job_q;

  logic signed [7:0] v;
  logic [6:0] mag, npeak, nspeak;
  logic [8:0] nfill;
  logic       close, sup;
  logic [SbW-1:0] nbd;
  logic       acc;

  assign in_ready_o = !full_q && !jv_q;
  assign acc = in_valid_i && in_ready_o;

  // saturate -128 and classify
  always_comb begin
    v      = (in_sample_i == 8'h80) ? -8'sd127 : $signed(in_sample_i);
    mag    = v[7] ? 7'(-v) : v[6:0];
    npeak  = (mag > peak_q) ? mag : peak_q;
    nfill  = fill_q + 9'd1;
    close  = (nfill == 9'(BLOCK_SIZE)) || in_final_i;
    nspeak = (npeak > speak_q) ? npeak : speak_q;
    nbd    = bdone_q + SbW'(1);
    sup    = (nbd == SbW'(SUPER_BLOCKS)) || in_final_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      peak_q  <= '0;
      speak_q <= '0;
      bdone_q <= '0;
      full_q  <= 1'b0;
      jv_q    <= 1'b0;
    end else begin
      if (jv_q && job_ready_i) jv_q <= 1'b0;
      if (buf_free_i) full_q <= 1'b0;
      if (acc) begin
        if (close) begin
          fill_q <= '0;
          peak_q <= '0;
          full_q <= 1'b1;
          jv_q   <= 1'b1;
          if (sup) begin
            bdone_q <= '0;
            speak_q <= '0;
          end else begin
            bdone_q <= nbd;
            speak_q <= nspeak;
          end
        end else begin
          fill_q <= nfill;
          peak_q <= npeak;
        end
      end
    end
  end

  // sample buffer and job payload
  always_ff @(posedge clk_i) begin
    if (acc) mem_q[fill_q[IdxW-1:0]] <= v;
    if (acc && close) begin
      job_q.fill       <= nfill;
      job_q.peak       <= npeak;
      job_q.emit_super <= sup;
      job_q.super_peak <= nspeak;
      job_q.fin        <= in_final_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

  assign job_valid_o = jv_q;
  assign job_o       = job_q;

`ifndef SYNTH
  a_no_acc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> !in_ready_o) else $error("accept while buffer busy");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 9'(BLOCK_SIZE)) else $error("fill overflow");
  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jv_q && !job_ready_i |=> jv_q) else $error("job dropped");
`endif
endmodule

[rtl/nf4q_back.sv]
// module: back end, normalizes samples, packs code bytes, emits scales
module nf4q_back
  import nf4q_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  output logic        buf_free_o,
  output logic [$clog2(BLOCK_SIZE)-1:0] rd_addr_o,
  input  logic [7:0]  rd_data_i,
  input  logic [AddrW-1:0] weight_base_i,
  input  logic [AddrW-1:0] scale_base_i,
  input  logic [AddrW-1:0] super_base_i,
  output logic        out_valid_o,
  output result_t     out_o,
  input  logic        out_ready_i
);
  localparam int unsigned IdxW = $clog2(BLOCK_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_READ, S_WAIT, S_DIV, S_BYTE, S_SUPER
  } state_e;

  state_e state_q;
  job_t   job_q;
  logic [8:0] pos_q;     // sample index being coded
  logic       half_q;    // 0 low nibble, 1 high nibble
  logic [3:0] lo_q;
  logic       neg_q;
  logic [AddrW-1:0] bcnt_q, scnt_q, sscnt_q;
  logic       ov_q;
  result_t    o_q;
  logic       free_q;

  logic       div_start, div_busy, div_done;
  logic [12:0] div_q;
  logic [6:0] mag;
  logic signed [7:0] nval;
  logic [3:0] code;
  logic       slot;

  assign slot = !ov_q || out_ready_i;

  // magnitude of buffered sample, or zero past the tail
  assign mag = (pos_q >= job_q.fill) ? 7'd0 :
               (rd_data_i[7] ? 7'(-$signed(rd_data_i)) : rd_data_i[6:0]);
  assign div_start = (state_q == S_WAIT) && (job_q.peak != 7'd0);

  nf4q_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, 6'd0}),
    .divisor_i  (job_q.peak),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // quotient is at most 64 since |v| <= peak
  always_comb begin
    nval = neg_q ? -$signed({1'b0, div_q[6:0]}) : $signed({1'b0, div_q[6:0]});
    code = nf4_map((job_q.peak == 7'd0) ? 8'sd0 : nval);
  end

  assign rd_addr_o   = pos_q[IdxW-1:0];
  assign job_ready_o = (state_q == S_IDLE);
  assign buf_free_o  = free_q;
  assign out_valid_o = ov_q;
  assign out_o       = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      half_q  <= 1'b0;
      bcnt_q  <= '0;
      scnt_q  <= '0;
      sscnt_q <= '0;
      ov_q    <= 1'b0;
      o_q     <= '0;
      free_q  <= 1'b0;
    end else begin
      free_q <= 1'b0;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            state_q <= S_SCALE;
            pos_q   <= '0;
            half_q  <= 1'b0;
          end
        end
        S_SCALE: begin
          if (slot) begin
            ov_q       <= 1'b1;
            o_q.kind    <= KIND_SCALE;
            o_q.payload <= {1'b0, job_q.peak};
            o_q.address <= scale_base_i + scnt_q;
            o_q.run_end <= 1'b0;
            scnt_q     <= scnt_q + AddrW'(1);
            state_q    <= S_READ;
          end
        end
        S_READ: state_q <= S_WAIT;
        S_WAIT: state_q <= (job_q.peak != 7'd0) ? S_DIV : S_BYTE;
        S_DIV:  if (div_done) state_q <= S_BYTE;
        S_BYTE: begin
          if (!half_q) begin
            half_q  <= 1'b1;
            pos_q   <= pos_q + 9'd1;
            state_q <= S_READ;
          end else if (slot) begin
            ov_q        <= 1'b1;
            o_q.kind    <= KIND_CODE;
            o_q.payload <= {code, lo_q};
            o_q.address <= weight_base_i + bcnt_q;
            bcnt_q      <= bcnt_q + AddrW'(1);
            half_q      <= 1'b0;
            pos_q       <= pos_q + 9'd1;
            if (pos_q + 9'd1 >= job_q.fill) begin
              free_q <= 1'b1;
              if (job_q.emit_super) begin
                o_q.run_end <= 1'b0;
                state_q     <= S_SUPER;
              end else begin
                o_q.run_end <= 1'b1;
                state_q     <= S_IDLE;
                if (job_q.fin) begin
                  bcnt_q <= '0;
                  scnt_q <= '0;
                  sscnt_q <= '0;
                end
              end
            end else begin
              o_q.run_end <= 1'b0;
              state_q     <= S_READ;
            end
          end
        end
        S_SUPER: begin
          if (slot) begin
            ov_q        <= 1'b1;
            o_q.kind    <= KIND_SUPER;
            o_q.payload <= {1'b0, job_q.super_peak};
            o_q.address <= super_base_i + sscnt_q;
            o_q.run_end <= 1'b1;
            sscnt_q     <= sscnt_q + AddrW'(1);
            state_q     <= S_IDLE;
            if (job_q.fin) begin
              bcnt_q  <= '0;
              scnt_q  <= '0;
              sscnt_q <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // job capture, sign and low nibble
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == S_WAIT) neg_q <= (pos_q < job_q.fill) && rd_data_i[7];
    if (state_q == S_BYTE && !half_q) lo_q <= code;
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(o_q)) else $error("result lost");
  a_free_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q |-> $past(state_q == S_BYTE)) else $error("buffer freed early");
`endif
endmodule

[rtl/nf4_block_quantizer.sv]
// top level: nf4 block quantizer with double quantization
//   channel   dir  payload                                   handshake
//   in_if     in   sample[8] signed, final_req[1]            valid/ready
//   out_if    out  kind[2], payload[8], address[20], run_end  valid/ready
//   cfg       in   cfg_we_i, cfg_idx_i[2], cfg_data_i[20]     write enable
// samples enter one per cycle while a block fills; on block close the back
// end picks up the job and sends the scale, then codes each nibble (read,
// wait, divide in the shared 13-step divider, pack), two nibbles per code
// byte, skipping the divider with a zero scale, and sends a superblock scale
// last when one is due; input stalls until the block buffer is released.
// reset is asynchronous active low; no clearing pass; output holds on stall.
module nf4_block_quantizer
  import nf4q_pkg::*;
  import nf4q_in_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE   = 64,
  parameter int unsigned SUPER_BLOCKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  nf4q_if.sink            in_if,
  nf4q_if.source          out_if,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [AddrW-1:0] cfg_data_i
);
  logic [AddrW-1:0] wbase_q, sbase_q, ssbase_q;
  logic job_valid, job_ready, buf_free;
  job_t job;
  logic [$clog2(BLOCK_SIZE)-1:0] rd_addr;
  logic [7:0] rd_data;
  in_item_t   in_item;

  assign in_item = in_if.data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbase_q  <= '0;
      sbase_q  <= '0;
      ssbase_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WEIGHT_BASE: wbase_q  <= cfg_data_i;
        REG_SCALE_BASE:  sbase_q  <= cfg_data_i;
        REG_SUPER_BASE:  ssbase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nf4q_front #(.BLOCK_SIZE(BLOCK_SIZE), .SUPER_BLOCKS(SUPER_BLOCKS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_sample_i (in_item.sample),
    .in_final_i  (in_item.final_req),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready),
    .buf_free_i  (buf_free),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  nf4q_back #(.BLOCK_SIZE(BLOCK_SIZE)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .buf_free_o    (buf_free),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .weight_base_i (wbase_q),
    .scale_base_i  (sbase_q),
    .super_base_i  (ssbase_q),
    .out_valid_o   (out_if.valid),
    .out_o         (out_if.data),
    .out_ready_i   (out_if.ready)
  );

`ifndef SYNTH
  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.kind != 2'd3) else $error("bad result kind");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("valid dropped");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !out_if.valid) else $error("config write while busy");
`endif
endmodule

[tb/tb_nf4_block_quantizer.sv]
// testbench: nf4 block quantizer checked against a behavioral predictor
module tb_nf4_block_quantizer;
  import nf4q_pkg::*;
  import nf4q_in_pkg::*;

  localparam int unsigned BlockSize   = 64;
  localparam int unsigned SuperBlocks = 256;
  localparam logic [AddrW-1:0] AddrMax = '1;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [AddrW-1:0] cfg_data_i;

  nf4q_if #(.T(in_item_t)) in_ch ();
  nf4q_if #(.T(result_t))  out_ch ();

  nf4_block_quantizer #(
    .BLOCK_SIZE  (BlockSize),
    .SUPER_BLOCKS(SuperBlocks)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic signed [7:0] pend_samples [BlockSize];
  int unsigned       pend_fill;
  logic [6:0]        pend_peak;
  int unsigned       closed_blocks;
  logic [6:0]        range_peak;
  logic [AddrW-1:0]  code_cnt, scale_cnt, super_cnt;
  logic [AddrW-1:0]  code_base, scale_base_q, super_base;

  result_t expected_results [$];
  int unsigned mismatch_count;
  int unsigned stall_left;
  bit idle_enable;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // nearest nf4 code of a sample scaled by the block peak
  function automatic logic [3:0] nearest_code(input int v, input int peak);
    int levels [16] = '{-64, -45, -34, -26, -19, -12, -6, 0, 5, 10, 15, 21, 28, 36, 46, 64};
    int n, mag, d, best_d;
    logic [3:0] best;
    n = 0;
    if (peak != 0) begin
      mag = ((v < 0 ? -v : v) * 64) / peak;
      n = (v < 0) ? -mag : mag;
    end
    best = 4'd0;
    best_d = (n - levels[0] < 0) ? levels[0] - n : n - levels[0];
    for (int i = 1; i < 16; i++) begin
      d = (n - levels[i] < 0) ? levels[i] - n : n - levels[i];
      if (d < best_d) begin
        best_d = d;
        best = 4'(i);
      end
    end
    return best;
  endfunction

  function automatic void push_result(kind_e k, logic [7:0] p, logic [AddrW-1:0] a);
    result_t r;
    r.kind = k;
    r.payload = p;
    r.address = a;
    r.run_end = 1'b0;
    expected_results.push_back(r);
  endfunction

  // predict the results of one accepted sample
  function automatic void predict_sample(input in_item_t it);
    int v, a, b;
    int n_before;
    v = int'(it.sample);
    if (v < -127) v = -127;
    n_before = expected_results.size();
    pend_samples[pend_fill % BlockSize] = 8'(v);
    if ((v < 0 ? -v : v) > int'(pend_peak)) pend_peak = 7'(v < 0 ? -v : v);
    pend_fill++;
    if (pend_fill >= BlockSize || it.final_req) begin
      push_result(KIND_SCALE, {1'b0, pend_peak}, scale_base_q + scale_cnt);
      scale_cnt++;
      for (int i = 0; i < pend_fill; i += 2) begin
        a = int'(pend_samples[i]);
        b = (i + 1 < pend_fill) ? int'(pend_samples[i + 1]) : 0;
        push_result(KIND_CODE, {nearest_code(b, int'(pend_peak)),
                                nearest_code(a, int'(pend_peak))},
                    code_base + code_cnt);
        code_cnt++;
      end
      if (pend_peak > range_peak) range_peak = pend_peak;
      closed_blocks++;
      pend_fill = 0;
      pend_peak = '0;
      if (closed_blocks >= SuperBlocks || it.final_req) begin
        push_result(KIND_SUPER, {1'b0, range_peak}, super_base + super_cnt);
        super_cnt++;
        closed_blocks = 0;
        range_peak = '0;
      end
      if (it.final_req) begin
        code_cnt = '0;
        scale_cnt = '0;
        super_cnt = '0;
      end
    end
    if (expected_results.size() > n_before)
      expected_results[expected_results.size() - 1].run_end = 1'b1;
  endfunction

  // send one item, with optional random idle burst before it
  task automatic send_sample(input logic signed [7:0] s, input logic fin);
    in_item_t it;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    it.sample = s;
    it.final_req = fin;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_sample(it);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // wait for all expected results, then let the back end settle
  task automatic wait_drained();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // write enable stays high across back to back writes
  task automatic write_reg(input reg_idx_e idx, input logic [AddrW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_WEIGHT_BASE: code_base = val;
      REG_SCALE_BASE:  scale_base_q = val;
      default:         super_base = val;
    endcase
  endtask

  task automatic set_bases(input logic [AddrW-1:0] w, s, u);
    write_reg(REG_WEIGHT_BASE, w);
    write_reg(REG_SCALE_BASE, s);
    write_reg(REG_SUPER_BASE, u);
    cfg_we_i <= 1'b0;
  endtask

  // directed: extremes, saturation, odd tail, zero scale, ties
  task automatic test_directed();
    send_sample(-8'sd128, 1'b0);
    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd127, 1'b1);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd0, 1'b1);
    send_sample(8'sd64, 1'b1);
    send_sample(8'sd64, 1'b0);
    send_sample(8'sd3, 1'b0);
    send_sample(-8'sd3, 1'b0);
    send_sample(8'sd13, 1'b0);
    send_sample(-8'sd9, 1'b0);
    send_sample(8'sd32, 1'b0);
    send_sample(-8'sd1, 1'b1);
    send_sample(8'sd85, 1'b0);
    send_sample(-8'sd42, 1'b0);
    send_sample(8'sd1, 1'b1);
    wait_drained();
  endtask

  // full blocks with random content through address wrap
  task automatic test_full_blocks();
    set_bases(AddrMax - 20'd3, AddrMax, AddrMax);
    for (int i = 0; i < 2 * BlockSize; i++)
      send_sample(8'($urandom_range(0, 255)), 1'b0);
    send_sample(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();
  endtask

  // random ranges of random length, mostly short
  task automatic test_random_ranges(input int unsigned n_items);
    int unsigned sent, scale_sel;
    logic signed [7:0] s;
    set_bases(20'($urandom), 20'($urandom), 20'($urandom));
    sent = 0;
    while (sent < n_items) begin
      scale_sel = $urandom_range(0, 3);
      case (scale_sel)
        0: s = 8'($urandom_range(0, 255));
        1: s = 8'(int'($urandom_range(0, 16)) - 8);
        2: s = 8'sd0;
        default: s = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      endcase
      sent++;
      send_sample(s, (sent == n_items) || ($urandom_range(0, 19) == 0));
    end
    wait_drained();
  endtask

  // result checker and output stall bursts
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %p", out_ch.data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.data.kind !== exp_r.kind || out_ch.data.payload !== exp_r.payload ||
            out_ch.data.address !== exp_r.address ||
            out_ch.data.run_end !== exp_r.run_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p got %p", exp_r, out_ch.data);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WEIGHT_BASE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    idle_enable = 1'b1;
    mismatch_count = 0;
    stall_left = 0;
    pend_fill = 0;
    pend_peak = '0;
    closed_blocks = 0;
    range_peak = '0;
    code_cnt = '0;
    scale_cnt = '0;
    super_cnt = '0;
    code_base = '0;
    scale_base_q = '0;
    super_base = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_blocks();
    test_random_ranges(130);
    set_bases('0, '0, '0);
    idle_enable = 1'b0;
    test_random_ranges(70);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_nf4_block_quantizer passed");
    end else begin
      $display("tb_nf4_block_quantizer failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #20000000;
    $display("tb_nf4_block_quantizer failed");
    $finish;
  end

endmodule
